### rtl/core/bdpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpc_pkg
// Types, codes and the per-button poll function of the two-button debounce
// and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TIME = 1'b1;

    localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST   = 16'd30;
    localparam logic [CFG_W-1:0] LONG_PRESS_TIME_RST = 16'd800;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_KEY_SHORT  = 3'd1,
        EV_KEY_LONG   = 3'd2,
        EV_BOOT_SHORT = 3'd3,
        EV_BOOT_LONG  = 3'd4
    } t_event;

    // Debounce and press tracking state of one button.
    typedef struct packed {
        logic              released;
        logic [TIME_W-1:0] change_stamp;
        logic [TIME_W-1:0] press_stamp;
        logic              long_done;
    } t_btn_state;

    typedef struct packed {
        t_btn_state state;
        logic       fire_short;
        logic       fire_long;
    } t_btn_result;

    localparam t_btn_state BTN_RST = '{
        released:     1'b1,
        change_stamp: '0,
        press_stamp:  '0,
        long_done:    1'b0
    };

    // One poll of one button. A zero stamp means unset; differences wrap.
    function automatic t_btn_result poll_button(
        input t_btn_state        st,
        input logic              pressed,
        input logic [TIME_W-1:0] now,
        input logic [CFG_W-1:0]  debounce_time,
        input logic [CFG_W-1:0]  long_press_time
    );
        t_btn_result       res;
        logic              target;
        logic              differ;
        logic [TIME_W-1:0] cs_eff;
        logic [TIME_W-1:0] d_change;
        logic [TIME_W-1:0] d_press;
        logic              accept;
        logic              ps_set;
        logic              in_time;
        res      = '{state: st, fire_short: 1'b0, fire_long: 1'b0};
        target   = ~pressed;
        differ   = (target != st.released);
        cs_eff   = (st.change_stamp == '0) ? now : st.change_stamp;
        d_change = now - cs_eff;
        d_press  = now - st.press_stamp;
        accept   = differ && (d_change >= {{(TIME_W-CFG_W){1'b0}}, debounce_time});
        ps_set   = (st.press_stamp != '0);
        in_time  = (d_press < {{(TIME_W-CFG_W){1'b0}}, long_press_time});

        res.state.change_stamp = (differ && !accept) ? cs_eff : '0;

        if (accept && !target) begin
            // Press accepted: the held time is zero on this poll.
            res.state.released    = 1'b0;
            res.state.press_stamp = now;
            res.state.long_done   = 1'b0;
            if ((now != '0) && (long_press_time == '0)) begin
                res.state.long_done = 1'b1;
                res.fire_long       = 1'b1;
            end
        end else if (accept) begin
            // Release accepted: short event only if the long event is not out.
            res.state.released    = 1'b1;
            res.state.press_stamp = '0;
            res.fire_short        = !st.long_done && ps_set && in_time;
        end else if (!st.released && !st.long_done && ps_set && !in_time) begin
            res.state.long_done = 1'b1;
            res.fire_long       = 1'b1;
        end
        return res;
    endfunction

endpackage

### rtl/core/button_debounce_press_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// Debounces two buttons (key and boot) from timestamped polls and classifies
// each accepted press as a short or a long press.
// ----------------------------------------------------------------------------
// The block takes one poll per clock cycle while o_in_stall is low and gives
// exactly one result per poll: the poll lands in an input register, and once
// the result register is free the per-button logic (two 32-bit wrapping
// subtractions with compares per button) updates the button state and loads
// the result register. Because the button state is written in the same cycle
// as the result, the following poll sees it without any bubble. A stall on
// the output only holds the input side once both the result register and the
// input register are full. The debounce and long-press times are written
// through the configuration channel, which is always ready; they should be
// written while no poll is in flight. A zero timestamp stands for "unset", so
// a press accepted at time zero never yields an event, and the key button wins
// over the boot button on a shared poll.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Poll channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_key_pressed_raw,
    input  logic                                i_boot_pressed_raw,
    input  logic [bdpc_pkg::TIME_W-1:0]         i_now_ms,
    // Result channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [2:0]                          o_event_code,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bdpc_pkg::CFG_W-1:0]          i_cfg_data
);

    // Configuration registers.
    logic [bdpc_pkg::CFG_W-1:0] r_debounce_time;
    logic [bdpc_pkg::CFG_W-1:0] r_long_press_time;

    // Input register stage.
    logic                        r_s1_valid;
    logic                        r_s1_key;
    logic                        r_s1_boot;
    logic [bdpc_pkg::TIME_W-1:0] r_s1_now;

    // Button state.
    bdpc_pkg::t_btn_state r_key;
    bdpc_pkg::t_btn_state r_boot;

    // Result register.
    logic             r_out_valid;
    bdpc_pkg::t_event r_event;
    bdpc_pkg::t_event n_event;

    bdpc_pkg::t_btn_result key_res;
    bdpc_pkg::t_btn_result boot_res;

    logic out_free;
    logic s1_advance;
    logic in_xfer;
    logic key_fired;

    // The result register can take a new value when it is empty or its
    // current value leaves in this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_advance = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_event_code = r_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_time   <= bdpc_pkg::DEBOUNCE_TIME_RST;
            r_long_press_time <= bdpc_pkg::LONG_PRESS_TIME_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bdpc_pkg::CFG_DEBOUNCE_TIME:   r_debounce_time   <= i_cfg_data;
                bdpc_pkg::CFG_LONG_PRESS_TIME: r_long_press_time <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: the poll payload is captured on each transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_key  <= i_key_pressed_raw;
            r_s1_boot <= i_boot_pressed_raw;
            r_s1_now  <= i_now_ms;
        end
    end

    // Both buttons are evaluated in parallel; the boot result is only used
    // and committed when the key button gives no event.
    always_comb begin
        key_res  = bdpc_pkg::poll_button(r_key, r_s1_key, r_s1_now,
                                         r_debounce_time, r_long_press_time);
        boot_res = bdpc_pkg::poll_button(r_boot, r_s1_boot, r_s1_now,
                                         r_debounce_time, r_long_press_time);
    end

    assign key_fired = key_res.fire_short || key_res.fire_long;

    always_comb begin
        if (key_res.fire_short) begin
            n_event = bdpc_pkg::EV_KEY_SHORT;
        end else if (key_res.fire_long) begin
            n_event = bdpc_pkg::EV_KEY_LONG;
        end else if (boot_res.fire_short) begin
            n_event = bdpc_pkg::EV_BOOT_SHORT;
        end else if (boot_res.fire_long) begin
            n_event = bdpc_pkg::EV_BOOT_LONG;
        end else begin
            n_event = bdpc_pkg::EV_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= bdpc_pkg::BTN_RST;
            r_boot <= bdpc_pkg::BTN_RST;
        end else if (s1_advance) begin
            r_key <= key_res.state;
            if (!key_fired) begin
                r_boot <= boot_res.state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_event <= n_event;
        end
    end

    // A released button never holds a press time.
    a_key_release_clears_press: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_key.released |-> (r_key.press_stamp == '0)
    ) else $error("key released with a press time still set");

    a_boot_release_clears_press: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_boot.released |-> (r_boot.press_stamp == '0)
    ) else $error("boot released with a press time still set");

    // A key event leaves the boot state untouched on that poll.
    a_key_event_holds_boot: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (s1_advance && key_fired) |=> $stable(r_boot)
    ) else $error("boot state changed on a poll with a key event");

    // A long key event marks the press as done.
    a_key_long_marks_done: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (s1_advance && key_res.fire_long) |=> (r_key.long_done && !r_key.released)
    ) else $error("long key event without long_done set");

endmodule
